FILE: rtl/core/scmv_pkg.sv
// ----------------------------------------------------------------------------
// scmv_pkg
// Shared widths, operation codes, register indexes and types of the CSR
// sparse matrix-vector block.
// ----------------------------------------------------------------------------
package scmv_pkg;

    localparam int VEC_LEN_DEF = 1024;
    localparam int OUT_DEPTH   = 16;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 48;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_ENTRY = 2'd1,
        OP_EMPTY = 2'd2
    } t_op;

    localparam logic [CFG_A_W-1:0] REG_SCALED_MODE = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_SCALE_A     = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_SCALE_B     = 2'd2;

    localparam logic signed [VAL_W-1:0] SCALE_A_RST = 32'sd65536;

    localparam logic signed [ACC_W-1:0] MAX48 = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] MIN48 = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [ACC_W-1:0] row_result;
        logic                    saturated;
    } t_result;

    typedef struct packed {
        logic signed [ACC_W-1:0] val;
        logic                    clip;
    } t_sat;

endpackage

FILE: rtl/core/scmv_if.sv
// ----------------------------------------------------------------------------
// scmv_if
// Channel interfaces: input items, results and the configuration writes.
// ----------------------------------------------------------------------------
interface scmv_in_if
    import scmv_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    row_end;
    logic signed [ACC_W-1:0] prior_value;
    logic signed [VAL_W-1:0] addend;

    modport source (output valid, op, index, value, row_end, prior_value, addend,
                    input ready);
    modport sink   (input valid, op, index, value, row_end, prior_value, addend,
                    output ready);
endinterface

interface scmv_out_if
    import scmv_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] row_result;
    logic                    saturated;

    modport source (output valid, row_result, saturated, input ready);
    modport sink   (input valid, row_result, saturated, output ready);
endinterface

interface scmv_cfg_if
    import scmv_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CFG_A_W-1:0] index;
    logic [CFG_D_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/scmv_ram.sv
// ----------------------------------------------------------------------------
// scmv_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: rtl/core/scmv_out_fifo.sv
// ----------------------------------------------------------------------------
// scmv_out_fifo
// Result queue between the arithmetic pipeline and the output channel.
// Space is reserved upstream, so a push never meets a full queue.
// ----------------------------------------------------------------------------
module scmv_out_fifo
    import scmv_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(w_pop);
        end
    end

endmodule

FILE: rtl/core/sparse_csr_matvec.sv
// ----------------------------------------------------------------------------
// sparse_csr_matvec
// CSR sparse matrix times dense vector, Q16.16 in, Q32.16 out, saturating.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : load transfers (op LOAD) fill the vector store; matrix nonzeros
//           (op ENTRY) stream row by row, row_end on the last one; op EMPTY
//           closes a row with no further term.
//   o_out : one result per closed row: row sum, or in scaled mode
//           scale_a*(prior_value + sum) + scale_b*addend, with a clip flag.
//   i_cfg : register writes, always ready; write only while the block is idle.
// Throughput: one input transfer per cycle while i_in.ready is high. The vector
// store is a synchronous RAM with a registered read, followed by a product stage
// and a single accumulator register updated on each entry or empty item.
// Pipeline: the result of a closing transfer passes through the store read,
// product, accumulate, prior add, scaling products and scaled-term stages,
// then the final sum is written into the queue and offered on o_out.
// Stall: a 16-entry result queue absorbs a stalled receiver; i_in.ready
// drops once 16 results are outstanding and returns as results drain.
// Reset: accumulator, flag, pipeline and queue clear; the vector store is
// not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module sparse_csr_matvec
    import scmv_pkg::*;
#(
    parameter int VEC_LEN = VEC_LEN_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    scmv_in_if.sink      i_in,
    scmv_cfg_if.sink     i_cfg,
    scmv_out_if.source   o_out
);

    localparam int AW = $clog2(VEC_LEN);
    localparam int PW = $clog2(OUT_DEPTH + 1);

    function automatic t_sat sat48(input logic signed [64:0] v);
        t_sat s;
        s.clip = 1'b0;
        s.val  = v[ACC_W-1:0];
        if (v > 65'(MAX48)) begin
            s.clip = 1'b1;
            s.val  = MAX48;
        end else if (v < 65'(MIN48)) begin
            s.clip = 1'b1;
            s.val  = MIN48;
        end
        return s;
    endfunction

    // configuration
    logic                    r_scaled_mode;
    logic signed [VAL_W-1:0] r_scale_a;
    logic signed [VAL_W-1:0] r_scale_b;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scaled_mode <= 1'b0;
            r_scale_a     <= SCALE_A_RST;
            r_scale_b     <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SCALED_MODE: r_scaled_mode <= i_cfg.data[0];
                REG_SCALE_A:     r_scale_a     <= signed'(i_cfg.data);
                REG_SCALE_B:     r_scale_b     <= signed'(i_cfg.data);
                default:         ;
            endcase
        end
    end

    // input decode
    logic w_acc_in;
    logic w_is_load;
    logic w_is_entry;
    logic w_is_empty;
    logic w_close;
    logic w_in_range;

    assign w_acc_in   = i_in.valid && i_in.ready;
    assign w_is_load  = (i_in.op == OP_LOAD);
    assign w_is_entry = (i_in.op == OP_ENTRY);
    assign w_is_empty = (i_in.op == OP_EMPTY);
    assign w_close    = w_is_empty || (w_is_entry && i_in.row_end);
    assign w_in_range = (32'(i_in.index) < VEC_LEN);

    // vector store
    logic [VAL_W-1:0] w_rdata;

    scmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (VEC_LEN)
    ) u_vec_store (
        .i_clk   (i_clk),
        .i_we    (w_acc_in && w_is_load && w_in_range),
        .i_waddr (AW'(i_in.index)),
        .i_wdata (i_in.value),
        .i_re    (w_acc_in && w_is_entry),
        .i_raddr (AW'(i_in.index)),
        .o_rdata (w_rdata)
    );

    // stage 1: store read in flight
    logic                    r_s1_vld;
    logic                    r_s1_entry;
    logic                    r_s1_close;
    logic                    r_s1_inr;
    logic signed [VAL_W-1:0] r_s1_val;
    logic signed [ACC_W-1:0] r_s1_prior;
    logic signed [VAL_W-1:0] r_s1_add;

    // stage 2: product
    logic                    r_s2_vld;
    logic                    r_s2_close;
    logic signed [63:0]      r_s2_prod;
    logic signed [ACC_W-1:0] r_s2_prior;
    logic signed [VAL_W-1:0] r_s2_add;

    // accumulator
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_acc_sat;

    // stage 3: closed row
    logic                    r_s3_vld;
    logic signed [ACC_W-1:0] r_s3_sum;
    logic                    r_s3_flag;
    logic signed [ACC_W-1:0] r_s3_prior;
    logic signed [VAL_W-1:0] r_s3_add;

    // stage 4: prior added
    logic                    r_s4_vld;
    logic signed [ACC_W-1:0] r_s4_t;
    logic signed [ACC_W-1:0] r_s4_plain;
    logic                    r_s4_flag;
    logic                    r_s4_tclip;
    logic signed [VAL_W-1:0] r_s4_add;

    // stage 5: scaling products
    logic                    r_s5_vld;
    logic signed [63:0]      r_s5_ma;
    logic signed [48:0]      r_s5_mb;
    logic signed [63:0]      r_s5_mc;
    logic signed [ACC_W-1:0] r_s5_plain;
    logic                    r_s5_flag;
    logic                    r_s5_tclip;

    // stage 6: scaled terms
    logic                    r_s6_vld;
    logic signed [63:0]      r_s6_ta;
    logic signed [ACC_W-1:0] r_s6_tb;
    logic signed [ACC_W-1:0] r_s6_plain;
    logic                    r_s6_flag;
    logic                    r_s6_tclip;

    logic signed [VAL_W-1:0] w_x;
    logic signed [ACC_W-1:0] w_term;
    t_sat                    w_acc_new;
    t_sat                    w_t;
    t_sat                    w_fin;
    logic signed [32:0]      w_mb_sh;
    t_result                 w_res;

    assign w_x       = r_s1_inr ? signed'(w_rdata) : '0;
    assign w_term    = signed'(r_s2_prod[63:16]);
    assign w_acc_new = sat48(65'(r_acc) + 65'(w_term));
    assign w_t       = sat48(65'(r_s3_prior) + 65'(r_s3_sum));
    assign w_mb_sh   = signed'(r_s5_mb[48:16]);
    assign w_fin     = sat48(65'(r_s6_ta) + 65'(r_s6_tb));

    always_comb begin
        if (r_scaled_mode) begin
            w_res.row_result = w_fin.val;
            w_res.saturated  = r_s6_flag || r_s6_tclip || w_fin.clip;
        end else begin
            w_res.row_result = r_s6_plain;
            w_res.saturated  = r_s6_flag;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s1_entry <= w_is_entry;
        r_s1_close <= w_close;
        r_s1_inr   <= w_in_range;
        r_s1_val   <= i_in.value;
        r_s1_prior <= i_in.prior_value;
        r_s1_add   <= i_in.addend;

        r_s2_close <= r_s1_close;
        r_s2_prod  <= r_s1_entry ? r_s1_val * w_x : 64'sd0;
        r_s2_prior <= r_s1_prior;
        r_s2_add   <= r_s1_add;

        r_s3_sum   <= w_acc_new.val;
        r_s3_flag  <= r_acc_sat || w_acc_new.clip;
        r_s3_prior <= r_s2_prior;
        r_s3_add   <= r_s2_add;

        r_s4_t     <= w_t.val;
        r_s4_tclip <= w_t.clip;
        r_s4_plain <= r_s3_sum;
        r_s4_flag  <= r_s3_flag;
        r_s4_add   <= r_s3_add;

        // t split as signed upper 32 bits and unsigned lower 16 bits
        r_s5_ma    <= r_scale_a * signed'(r_s4_t[47:16]);
        r_s5_mb    <= r_scale_a * signed'({1'b0, r_s4_t[15:0]});
        r_s5_mc    <= r_scale_b * r_s4_add;
        r_s5_plain <= r_s4_plain;
        r_s5_flag  <= r_s4_flag;
        r_s5_tclip <= r_s4_tclip;

        r_s6_ta    <= r_s5_ma + 64'(w_mb_sh);
        r_s6_tb    <= signed'(r_s5_mc[63:16]);
        r_s6_plain <= r_s5_plain;
        r_s6_flag  <= r_s5_flag;
        r_s6_tclip <= r_s5_tclip;
    end

    // control and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_acc     <= '0;
            r_acc_sat <= 1'b0;
        end else begin
            r_s1_vld <= w_acc_in && (w_is_entry || w_is_empty);
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld && r_s2_close;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
            if (r_s2_vld) begin
                if (r_s2_close) begin
                    r_acc     <= '0;
                    r_acc_sat <= 1'b0;
                end else begin
                    r_acc     <= w_acc_new.val;
                    r_acc_sat <= r_acc_sat || w_acc_new.clip;
                end
            end
        end
    end

    // result queue and credit
    logic          w_out_vld;
    t_result       w_out_data;
    logic [PW-1:0] r_pend;
    logic          w_out_xfer;

    scmv_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s6_vld),
        .i_data  (w_res),
        .i_pop   (o_out.ready),
        .o_valid (w_out_vld),
        .o_data  (w_out_data)
    );

    assign o_out.valid      = w_out_vld;
    assign o_out.row_result = w_out_data.row_result;
    assign o_out.saturated  = w_out_data.saturated;
    assign w_out_xfer       = w_out_vld && o_out.ready;
    assign i_in.ready       = (r_pend < PW'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + PW'(w_acc_in && w_close) - PW'(w_out_xfer);
        end
    end

    // checks
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PW'(OUT_DEPTH))
        else $error("outstanding result count above queue depth");

    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_pend != '0))
        else $error("result offered with no outstanding credit");

    a_acc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_close) |=> (r_acc == '0 && !r_acc_sat))
        else $error("accumulator not cleared after row close");

    a_push_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s6_vld |-> (r_pend != '0))
        else $error("result pushed without reserved space");

endmodule

FILE: test/scmv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmv_checker
// Watches the item, configuration and result channels of the CSR
// matrix-vector block, keeps its own copy of the vector store, row
// accumulator and scaling registers, and checks every row result in order.
// ----------------------------------------------------------------------------
module scmv_checker
    import scmv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    scmv_in_if   i_in,
    scmv_cfg_if  i_cfg,
    scmv_out_if  i_out,
    output int   o_errors,
    output int   o_pending
);

    logic signed [VAL_W-1:0] vec_mem [VEC_LEN_DEF];
    logic signed [ACC_W-1:0] acc;
    logic                    acc_clip;
    logic                    scaled_on;
    logic signed [VAL_W-1:0] gain_a;
    logic signed [VAL_W-1:0] gain_b;
    t_result                 rows_due [$];
    t_result                 want;
    int                      err_cnt = 0;

    assign o_errors = err_cnt;

    // floor(p * q / 2^16), exact over the full operand ranges
    function automatic longint mul_q16(input logic signed [VAL_W-1:0] p,
                                       input logic signed [ACC_W-1:0] q);
        logic signed [79:0] pw;
        logic signed [79:0] qw;
        logic signed [79:0] prod;
        pw   = p;
        qw   = q;
        prod = pw * qw;
        return prod[79:16];
    endfunction

    function automatic t_sat clamp48(input longint v);
        t_sat s;
        s.clip = 1'b0;
        if (v > MAX48) begin
            s.val  = MAX48;
            s.clip = 1'b1;
        end else if (v < MIN48) begin
            s.val  = MIN48;
            s.clip = 1'b1;
        end else begin
            s.val = v[ACC_W-1:0];
        end
        return s;
    endfunction

    task automatic take_item();
        t_sat                    s;
        t_sat                    t;
        t_sat                    r;
        t_result                 res;
        logic signed [VAL_W-1:0] x;
        logic                    flag;
        case (i_in.op)
            OP_LOAD: vec_mem[i_in.index] = i_in.value;
            OP_ENTRY, OP_EMPTY: begin
                if (i_in.op == OP_ENTRY) begin
                    x        = vec_mem[i_in.index];
                    s        = clamp48(acc + mul_q16(i_in.value, x));
                    acc      = s.val;
                    acc_clip = acc_clip | s.clip;
                end
                // a row closes on a marked entry or on an empty-row item
                if (i_in.op == OP_EMPTY || i_in.row_end) begin
                    flag = acc_clip;
                    if (scaled_on) begin
                        t    = clamp48(i_in.prior_value + acc);
                        r    = clamp48(mul_q16(gain_a, t.val) + mul_q16(gain_b, i_in.addend));
                        flag = flag | t.clip | r.clip;
                        res.row_result = r.val;
                    end else begin
                        res.row_result = acc;
                    end
                    res.saturated = flag;
                    rows_due.push_back(res);
                    acc      = '0;
                    acc_clip = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc       = '0;
            acc_clip  = 1'b0;
            scaled_on = 1'b0;
            gain_a    = SCALE_A_RST;
            gain_b    = '0;
            rows_due.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (rows_due.size() == 0) begin
                    $error("row_result: no result expected, actual %0d", i_out.row_result);
                    err_cnt++;
                end else begin
                    want = rows_due.pop_front();
                    if (i_out.row_result !== want.row_result) begin
                        $error("row_result mismatch: expected %0d, actual %0d",
                               want.row_result, i_out.row_result);
                        err_cnt++;
                    end
                    if (i_out.saturated !== want.saturated) begin
                        $error("saturated mismatch: expected %0d, actual %0d",
                               want.saturated, i_out.saturated);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_SCALED_MODE: scaled_on = i_cfg.data[0];
                    REG_SCALE_A:     gain_a    = i_cfg.data;
                    REG_SCALE_B:     gain_b    = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                take_item();
            end
        end
        o_pending <= rows_due.size();
    end

endmodule

FILE: test/tb_sparse_csr_matvec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_csr_matvec
// Drives the CSR matrix-vector block with a directed set of corner rows and
// then random rows under several scaling settings, with random idling on
// both sides, a long receiver hold-off and pauses; the checker beside the
// block predicts and compares every row result.
// ----------------------------------------------------------------------------
module tb_sparse_csr_matvec;
    import scmv_pkg::*;

    localparam int LATENCY        = 7;
    localparam int SETTLE         = LATENCY + 4;
    localparam int GAP_MAX        = 12;
    localparam int HOLD_CYCLES    = 80;
    localparam int BURST_ROWS     = 48;
    localparam int PHASE_ITEMS    = 135;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   err_total;
    int   pending;
    int   idle_cycles = 0;

    bit   loaded [VEC_LEN_DEF];
    int   loaded_list [$];
    bit   hold_go    = 1'b0;
    bit   hold_taken = 1'b0;
    bit   tx_nogap   = 1'b0;
    bit   tx_calm    = 1'b0;
    int   tx_left    = 0;

    scmv_in_if  in_ch ();
    scmv_cfg_if cfg_ch ();
    scmv_out_if out_ch ();

    sparse_csr_matvec dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    scmv_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_cfg     (cfg_ch),
        .i_out     (out_ch),
        .o_errors  (err_total),
        .o_pending (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ends the run when no transfer happens on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [VAL_W-1:0] rand_q16();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return {{14{r[17]}}, r[17:0]};
            3:       return '0;
            default: return r;
        endcase
    endfunction

    function automatic logic [ACC_W-1:0] rand_q48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0:       return MAX48;
            1:       return MIN48;
            2:       return {{24{w[23]}}, w[23:0]};
            default: return w[ACC_W-1:0];
        endcase
    endfunction

    // only columns already loaded are ever read
    function automatic logic [IDX_W-1:0] pick_col();
        return IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val, input logic row_end,
                             input logic [ACC_W-1:0] prior, input logic [VAL_W-1:0] add);
        int gap;
        if (tx_left == 0) begin
            tx_left = $urandom_range(1, 40);
            tx_calm = ($urandom_range(0, 3) == 0);
        end
        tx_left--;
        gap = (tx_calm || tx_nogap) ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.op          <= op;
        in_ch.index       <= idx;
        in_ch.value       <= val;
        in_ch.row_end     <= row_end;
        in_ch.prior_value <= prior;
        in_ch.addend      <= add;
        in_ch.valid       <= 1'b1;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        if (op == OP_LOAD && !loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
    endtask

    // stop offering, wait for every outstanding row, then let loads settle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] data);
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
    endtask

    task automatic set_config(input logic mode, input logic [CFG_D_W-1:0] a,
                              input logic [CFG_D_W-1:0] b);
        drain_results();
        write_reg(REG_SCALED_MODE, {{(CFG_D_W-1){1'b0}}, mode});
        write_reg(REG_SCALE_A, a);
        write_reg(REG_SCALE_B, b);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(input int n_items);
        int               sent;
        int               len;
        bit               close_empty;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] val;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    // keep the extreme elements at both ends of the store
                    send_item(OP_LOAD, IDX_W'($urandom_range(1, VEC_LEN_DEF - 2)),
                              rand_q16(), 1'($urandom_range(0, 1)), rand_q48(), $urandom);
                    sent++;
                end
                2: begin
                    send_item(OP_UNUSED, IDX_W'($urandom_range(0, VEC_LEN_DEF - 1)),
                              $urandom, 1'($urandom_range(0, 1)), rand_q48(), $urandom);
                end
                3: begin
                    send_item(OP_EMPTY, IDX_W'($urandom_range(0, VEC_LEN_DEF - 1)),
                              $urandom, 1'($urandom_range(0, 1)), rand_q48(), rand_q16());
                    sent++;
                end
                4: begin
                    // same-sign extreme products, drives the accumulator into clipping
                    len = $urandom_range(3, 6);
                    col = $urandom_range(0, 1) ? IDX_W'(VEC_LEN_DEF - 1) : '0;
                    val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    for (int k = 0; k < len; k++) begin
                        send_item(OP_ENTRY, col, val, k == len - 1, rand_q48(), rand_q16());
                        sent++;
                    end
                end
                default: begin
                    len         = $urandom_range(1, 6);
                    close_empty = ($urandom_range(0, 7) == 0);
                    for (int k = 0; k < len; k++) begin
                        send_item(OP_ENTRY, pick_col(), rand_q16(),
                                  (k == len - 1) && !close_empty, rand_q48(), rand_q16());
                        sent++;
                    end
                    if (close_empty) begin
                        send_item(OP_EMPTY, IDX_W'($urandom_range(0, VEC_LEN_DEF - 1)),
                                  $urandom, 1'($urandom_range(0, 1)), rand_q48(),
                                  rand_q16());
                        sent++;
                    end
                end
            endcase
        end
    endtask

    // result receiver: random gaps per result, calm stretches, one long hold-off
    initial begin : rx_proc
        int gap;
        int left;
        bit calm;
        left = 0;
        calm = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (left == 0) begin
                left = $urandom_range(1, 40);
                calm = ($urandom_range(0, 3) == 0);
            end
            left--;
            gap = calm ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_LOAD;
        in_ch.index       <= '0;
        in_ch.value       <= '0;
        in_ch.row_end     <= 1'b0;
        in_ch.prior_value <= '0;
        in_ch.addend      <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_SCALED_MODE;
        cfg_ch.data       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // store: both extremes, one, minus one, one half
        send_item(OP_LOAD, 10'd0,    32'h7FFF_FFFF, 1'b0, '0, '0);
        send_item(OP_LOAD, 10'd1023, 32'h8000_0000, 1'b1, '0, '0);
        send_item(OP_LOAD, 10'd1,    32'h0001_0000, 1'b0, '0, '0);
        send_item(OP_LOAD, 10'd2,    32'hFFFF_0000, 1'b0, '0, '0);
        send_item(OP_LOAD, 10'd3,    32'h0000_8000, 1'b0, '0, '0);
        send_item(OP_ENTRY, 10'd0,    32'h7FFF_FFFF, 1'b0, '0, '0);
        send_item(OP_ENTRY, 10'd1023, 32'h8000_0000, 1'b1, '0, '0);
        // positive clip
        repeat (3) send_item(OP_ENTRY, 10'd1023, 32'h8000_0000, 1'b0, '0, '0);
        send_item(OP_ENTRY, 10'd1023, 32'h8000_0000, 1'b1, '0, '0);
        // floor rounding of half an lsb either way
        send_item(OP_ENTRY, 10'd3, 32'h0000_0001, 1'b1, '0, '0);
        send_item(OP_ENTRY, 10'd3, 32'hFFFF_FFFF, 1'b1, '0, '0);
        send_item(OP_ENTRY, 10'd2, 32'hFFFF_FFFF, 1'b1, '0, '0);
        // empty row with nothing pending, then a pending entry closed by an empty row
        send_item(OP_EMPTY, 10'd0, '0, 1'b1, MAX48, 32'h7FFF_FFFF);
        send_item(OP_ENTRY, 10'd1, 32'h0003_0000, 1'b0, '0, '0);
        send_item(OP_EMPTY, 10'd1023, 32'hFFFF_FFFF, 1'b0, MIN48, 32'h8000_0000);
        send_item(OP_UNUSED, 10'd1023, 32'hFFFF_FFFF, 1'b1, MIN48, 32'hFFFF_FFFF);
        // negative clip
        repeat (4) send_item(OP_ENTRY, 10'd1023, 32'h7FFF_FFFF, 1'b0, '0, '0);
        send_item(OP_ENTRY, 10'd0, 32'h8000_0000, 1'b1, '0, '0);

        run_random(PHASE_ITEMS);

        set_config(1'b1, SCALE_A_RST, '0);
        run_random(PHASE_ITEMS);
        // back-to-back rows against a stalled receiver fill the result queue
        drain_results();
        hold_go  = 1'b1;
        tx_nogap = 1'b1;
        repeat (BURST_ROWS) send_item(OP_ENTRY, pick_col(), rand_q16(), 1'b1,
                                      rand_q48(), rand_q16());
        tx_nogap = 1'b0;
        drain_results();

        set_config(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        run_random(PHASE_ITEMS);
        set_config(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        run_random(PHASE_ITEMS);
        set_config(1'b1, '0, $urandom);
        run_random(PHASE_ITEMS);
        set_config(1'b1, $urandom, $urandom);
        run_random(PHASE_ITEMS);
        set_config(1'b0, $urandom, $urandom);
        run_random(PHASE_ITEMS);

        drain_results();
        if (err_total == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
